FILE: rtl/core/dlmfifo_pkg.sv
// ============================================================================
// dlmfifo_pkg
// Shared types and constants for the delimited frame FIFO: command codes,
// field widths and the command/status bundles between controller and
// datapath.
// ============================================================================
package dlmfifo_pkg;

    // Default geometry
    localparam int DEPTH_DEFAULT      = 32;
    localparam int DATA_WIDTH_DEFAULT = 8;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int FILL_W    = 6;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CHECK = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_FIRST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_SECOND = 1'd1;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture the input transaction
        logic push;        // write one entry at the tail
        logic pop;         // remove one entry at the head
        logic scan_start;  // begin a frame scan at offset one
        logic scan_step;   // advance the frame scan by one entry
        logic len_load;    // delimiter found: latch frame length, rewind scan
        logic idx_clear;   // rewind scan offset to the head
        logic emit;        // load the output register
        logic emit_ok;
        logic emit_data;   // output carries the head entry
        logic emit_last;
    } dlmfifo_ctrl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic below_two;   // fewer than two entries stored
        logic pair_hit;    // delimiter pair at the current scan position
        logic scan_end;    // scan position is the newest stored entry
        logic pop_last;    // one frame entry left to pop
        logic tail_hit;    // delimiter check result
        logic out_free;    // output register can take a result
    } dlmfifo_stat_t;

endpackage

FILE: rtl/core/dlmfifo_ctrl.sv
// ============================================================================
// dlmfifo_ctrl
// Controller state machine: takes one transaction at a time, sequences the
// single-entry commands, the frame scan and the frame pop.
// ============================================================================
module dlmfifo_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [dlmfifo_pkg::CMD_W-1:0] s_command,
    input  dlmfifo_pkg::dlmfifo_stat_t  stat,
    output dlmfifo_pkg::dlmfifo_ctrl_t  ctrl
);
    import dlmfifo_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_POP  = 2'd3;

    logic [1:0]       st_reg;
    logic [1:0]       st_next;
    logic [CMD_W-1:0] cmd_reg;
    logic             accept;

    assign s_tready = (st_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Hold state and the latched command
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_IDLE;
            cmd_reg <= CMD_PUSH;
        end else begin
            st_reg <= st_next;
            if (accept) begin
                cmd_reg <= s_command;
            end
        end
    end

    // Decode next state and datapath commands
    always_comb begin
        st_next = st_reg;
        ctrl    = '0;
        unique case (st_reg)
            ST_IDLE: begin
                ctrl.load = accept;
                if (accept) begin
                    st_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (cmd_reg)
                    CMD_PUSH: begin
                        if (stat.out_free) begin
                            ctrl.emit      = 1'b1;
                            ctrl.emit_ok   = !stat.full;
                            ctrl.emit_last = 1'b1;
                            ctrl.push      = !stat.full;
                            st_next        = ST_IDLE;
                        end
                    end
                    CMD_POP: begin
                        if (stat.out_free) begin
                            ctrl.emit      = 1'b1;
                            ctrl.emit_ok   = !stat.empty;
                            ctrl.emit_data = !stat.empty;
                            ctrl.emit_last = 1'b1;
                            ctrl.pop       = !stat.empty;
                            st_next        = ST_IDLE;
                        end
                    end
                    CMD_FRAME: begin
                        if (!stat.below_two) begin
                            ctrl.scan_start = 1'b1;
                            st_next         = ST_SCAN;
                        end else if (stat.out_free) begin
                            ctrl.emit      = 1'b1;
                            ctrl.emit_last = 1'b1;
                            st_next        = ST_IDLE;
                        end
                    end
                    CMD_CHECK: begin
                        if (stat.out_free) begin
                            ctrl.emit      = 1'b1;
                            ctrl.emit_ok   = stat.tail_hit;
                            ctrl.emit_last = 1'b1;
                            st_next        = ST_IDLE;
                        end
                    end
                    default: begin
                        st_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN: begin
                if (stat.pair_hit) begin
                    ctrl.len_load = 1'b1;
                    st_next       = ST_POP;
                end else if (stat.scan_end) begin
                    // No delimiter among stored entries: refuse once
                    if (stat.out_free) begin
                        ctrl.emit      = 1'b1;
                        ctrl.emit_last = 1'b1;
                        ctrl.idx_clear = 1'b1;
                        st_next        = ST_IDLE;
                    end
                end else begin
                    ctrl.scan_step = 1'b1;
                end
            end
            ST_POP: begin
                if (stat.out_free) begin
                    ctrl.emit      = 1'b1;
                    ctrl.emit_ok   = 1'b1;
                    ctrl.emit_data = 1'b1;
                    ctrl.emit_last = stat.pop_last;
                    ctrl.pop       = 1'b1;
                    if (stat.pop_last) begin
                        st_next = ST_IDLE;
                    end
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/dlmfifo_dp.sv
// ============================================================================
// dlmfifo_dp
// Datapath: entry memory with registered read, pointers and count, scan
// offset and frame length, delimiter registers, tail history and the output
// register.
// ============================================================================
module dlmfifo_dp #(
    parameter int DEPTH      = dlmfifo_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = dlmfifo_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  dlmfifo_pkg::dlmfifo_ctrl_t       ctrl,
    output dlmfifo_pkg::dlmfifo_stat_t       stat,
    input  logic [dlmfifo_pkg::BYTE_W-1:0]   s_data_in,
    input  logic                             cfg_we,
    input  logic [dlmfifo_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [dlmfifo_pkg::BYTE_W-1:0]   cfg_wdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic                             m_ok,
    output logic [dlmfifo_pkg::BYTE_W-1:0]   m_data_out,
    output logic                             m_last,
    output logic [dlmfifo_pkg::FILL_W-1:0]   m_fill_level
);
    import dlmfifo_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (DATA_WIDTH > BYTE_W) ? DATA_WIDTH : BYTE_W;
    localparam int FW    = (CNT_W > FILL_W) ? CNT_W : FILL_W;

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_SUM = (PTR_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [DATA_WIDTH-1:0] prev_reg;
    logic [DATA_WIDTH-1:0] last1_reg;
    logic [DATA_WIDTH-1:0] last2_reg;
    logic [BYTE_W-1:0]     din_reg;
    logic [BYTE_W-1:0]     delim_first_reg;
    logic [BYTE_W-1:0]     delim_second_reg;

    logic [PTR_W-1:0] rd_reg;
    logic [PTR_W-1:0] rd_next;
    logic [PTR_W-1:0] wp_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [PTR_W-1:0] idx_reg;
    logic [PTR_W-1:0] idx_next;
    logic [CNT_W-1:0] len_reg;
    logic [PTR_W:0]   addr_sum;
    logic [PTR_W-1:0] rd_addr;

    logic [CMP_W-1:0]      din_ext;
    logic [DATA_WIDTH-1:0] din_keep;
    logic [CMP_W-1:0]      rd_ext;
    logic [FW-1:0]         fill_ext;
    logic                  out_free;

    logic                  out_valid_reg;
    logic                  out_ok_reg;
    logic [BYTE_W-1:0]     out_data_reg;
    logic                  out_last_reg;
    logic [FILL_W-1:0]     out_fill_reg;

    // Keep the pushed byte to the entry width
    assign din_ext  = CMP_W'(din_reg);
    assign din_keep = din_ext[DATA_WIDTH-1:0];
    assign rd_ext   = CMP_W'(rd_data_reg);

    // Next head pointer, count and scan offset
    always_comb begin
        rd_next = rd_reg;
        if (ctrl.pop) begin
            rd_next = (rd_reg == PTR_LAST) ? '0 : rd_reg + 1'b1;
        end
        cnt_next = cnt_reg;
        if (ctrl.push) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (ctrl.pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
        idx_next = idx_reg;
        if (ctrl.scan_start) begin
            idx_next = PTR_W'(1);
        end else if (ctrl.scan_step) begin
            idx_next = idx_reg + 1'b1;
        end else if (ctrl.len_load || ctrl.idx_clear) begin
            idx_next = '0;
        end
    end

    // Read address follows the next head and offset so read data lines up
    assign addr_sum = (PTR_W + 1)'(rd_next) + (PTR_W + 1)'(idx_next);
    assign rd_addr  = (addr_sum >= DEPTH_SUM) ? PTR_W'(addr_sum - DEPTH_SUM)
                                              : addr_sum[PTR_W-1:0];

    // Entry memory
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[wp_reg] <= din_keep;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    // Pointers, count, scan offset and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg           <= '0;
            wp_reg           <= '0;
            cnt_reg          <= '0;
            idx_reg          <= '0;
            delim_first_reg  <= '0;
            delim_second_reg <= '0;
        end else begin
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (ctrl.push) begin
                wp_reg <= (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
            end
            if (cfg_we) begin
                unique case (cfg_idx)
                    CFG_DELIM_FIRST:  delim_first_reg  <= cfg_wdata;
                    CFG_DELIM_SECOND: delim_second_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Payload: input byte, scan history, tail history, frame length
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            din_reg <= s_data_in;
        end
        if (ctrl.scan_start || ctrl.scan_step) begin
            prev_reg <= rd_data_reg;
        end
        if (ctrl.push) begin
            last2_reg <= last1_reg;
            last1_reg <= din_keep;
        end
        if (ctrl.len_load) begin
            len_reg <= CNT_W'(idx_reg) + 1'b1;
        end else if (ctrl.pop) begin
            len_reg <= len_reg - 1'b1;
        end
    end

    // Status toward the controller
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        stat.empty     = (cnt_reg == '0);
        stat.full      = (cnt_reg == CNT_DEPTH);
        stat.below_two = (cnt_reg < CNT_TWO);
        stat.pair_hit  = (CMP_W'(prev_reg) == CMP_W'(delim_first_reg))
                      && (CMP_W'(rd_data_reg) == CMP_W'(delim_second_reg));
        stat.scan_end  = ((CNT_W'(idx_reg) + 1'b1) == cnt_reg);
        stat.pop_last  = (len_reg == CNT_ONE);
        stat.tail_hit  = ((delim_first_reg == '0) && (delim_second_reg == '0))
                      || ((cnt_reg >= CNT_TWO)
                          && (CMP_W'(last2_reg) == CMP_W'(delim_first_reg))
                          && (CMP_W'(last1_reg) == CMP_W'(delim_second_reg)));
        stat.out_free  = out_free;
    end

    // Output register
    assign fill_ext = FW'(cnt_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            out_ok_reg   <= ctrl.emit_ok;
            out_data_reg <= ctrl.emit_data ? rd_ext[BYTE_W-1:0] : '0;
            out_last_reg <= ctrl.emit_last;
            out_fill_reg <= fill_ext[FILL_W-1:0];
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_ok         = out_ok_reg;
    assign m_data_out   = out_data_reg;
    assign m_last       = out_last_reg;
    assign m_fill_level = out_fill_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_DEPTH)
        else $error("stored count above depth");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push |-> !stat.full)
        else $error("write into a full buffer");

    a_pop_data: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop |-> !stat.empty)
        else $error("pop from an empty buffer");

    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit |-> out_free)
        else $error("result overwrites a pending result");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wp_reg == rd_reg))
        else $error("pointers disagree with an empty count");
`endif

endmodule

FILE: rtl/core/delimited_frame_fifo.sv
// ============================================================================
// delimited_frame_fifo
// Circular entry FIFO that pops whole frames ending in a two-entry
// delimiter, plus single push, single pop and tail delimiter check.
// ============================================================================
//
//  Channel | Direction | Fields (from bit 0 up)
//  --------+-----------+----------------------------------------------------
//  s_      | in        | tdata: command[1:0], data_in[9:2], zero pad[15:10]
//  m_      | out       | tdata: ok[0], data_out[8:1], fill_level[14:9],
//          |           |        zero pad[15]; tlast: last
//  cfg_    | in        | cfg_idx 0 delim_first, 1 delim_second
//
//  Push, pop and check are accepted in the idle state, then done in the
//  execute state. Pop frame scans from the head for the delimiter pair and
//  pops the frame one entry per result; with no pair among stored entries,
//  or fewer than two stored, it refuses. The frame scan walks stored entries
//  one per cycle through the single read port of the entry memory.
//  Reset (aresetn low, synchronous) clears pointers, count, delimiters and
//  control; memory contents are not cleared. An m_ stall holds only steps that
//  emit a result; s_tready is high only between transactions.
//
module delimited_frame_fifo #(
    parameter int DEPTH      = dlmfifo_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = dlmfifo_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dlmfifo_pkg::S_TDATA_W-1:0]   s_tdata,  // command, data_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dlmfifo_pkg::M_TDATA_W-1:0]   m_tdata,  // ok, data_out, fill_level
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [dlmfifo_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [dlmfifo_pkg::BYTE_W-1:0]      cfg_wdata
);
    import dlmfifo_pkg::*;

    dlmfifo_ctrl_t     ctrl;
    dlmfifo_stat_t     stat;
    logic [CMD_W-1:0]  s_command;
    logic [BYTE_W-1:0] s_data_in;
    logic              m_ok;
    logic [BYTE_W-1:0] m_data_out;
    logic [FILL_W-1:0] m_fill_level;

    // Unpack the input transaction
    assign s_command = s_tdata[CMD_W-1:0];
    assign s_data_in = s_tdata[CMD_W+BYTE_W-1:CMD_W];

    dlmfifo_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_command (s_command),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    dlmfifo_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .stat         (stat),
        .s_data_in    (s_data_in),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_wdata    (cfg_wdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_ok         (m_ok),
        .m_data_out   (m_data_out),
        .m_last       (m_tlast),
        .m_fill_level (m_fill_level)
    );

    // Pack the result transaction
    assign m_tdata = {1'b0, m_fill_level, m_data_out, m_ok};

endmodule

FILE: sim/delimited_frame_fifo_test.sv
// ----------------------------------------------------------------------------
// delimited_frame_fifo_test
// Self-checking bench for the delimited frame FIFO. A shadow FIFO in the
// bench predicts every result transaction (ok, popped byte, last flag and
// fill level) for push, pop, frame pop and tail delimiter check. Directed
// corner cases come first. A back-pressure run fills the FIFO to overflow.
// Random frame traffic then runs under several delimiter settings, with
// random gaps on the input and the result channel, but for one gapless run.
// ----------------------------------------------------------------------------
module delimited_frame_fifo_test;
    import dlmfifo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIFO_DEPTH = DEPTH_DEFAULT;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic              ok;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [FILL_W-1:0] fill;
    } beat_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // command, data_in
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // ok, data_out, fill_level
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [BYTE_W-1:0]     cfg_wdata;

    // Shadow FIFO state
    logic [BYTE_W-1:0] fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  head_ptr    = '0;
    logic [PTR_W-1:0]  tail_ptr    = '0;
    int                fill_count  = 0;
    logic [BYTE_W-1:0] delim_lead  = '0;
    logic [BYTE_W-1:0] delim_trail = '0;

    beat_t due_beats [$];
    int    errors        = 0;
    int    hold_request  = 0;
    bit    steady_flow   = 1'b0;

    delimited_frame_fifo dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 92)
            return $urandom_range(3, 8);
        else
            return $urandom_range(12, 40);
    endfunction

    // Byte biased toward the delimiter values so that pairs form often
    function automatic logic [BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return delim_lead;
        else if (r == 1)
            return delim_trail;
        else
            return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic void queue_beat(input logic ok, input logic [BYTE_W-1:0] data,
                                       input logic last);
        beat_t b;
        b.ok   = ok;
        b.data = data;
        b.last = last;
        b.fill = fill_count[FILL_W-1:0];
        due_beats.push_back(b);
    endfunction

    // Apply one command to the shadow FIFO and queue the results it causes
    task automatic apply_fifo_command(input logic [CMD_W-1:0] cmd,
                                      input logic [BYTE_W-1:0] din);
        int                frame_len;
        logic [PTR_W-1:0]  scan_ptr;
        logic [PTR_W-1:0]  next_ptr;
        logic [PTR_W-1:0]  newest;
        logic [PTR_W-1:0]  older;
        logic [BYTE_W-1:0] v;
        logic              seen;
        frame_len = 0;
        case (cmd)
            CMD_PUSH: begin
                if (fill_count < FIFO_DEPTH) begin
                    fifo_mem[tail_ptr] = din;
                    tail_ptr = tail_ptr + 1'b1;
                    fill_count++;
                    queue_beat(1'b1, '0, 1'b1);
                end else begin
                    queue_beat(1'b0, '0, 1'b1);
                end
            end
            CMD_POP: begin
                if (fill_count > 0) begin
                    v = fifo_mem[head_ptr];
                    head_ptr = head_ptr + 1'b1;
                    fill_count--;
                    queue_beat(1'b1, v, 1'b1);
                end else begin
                    queue_beat(1'b0, '0, 1'b1);
                end
            end
            CMD_FRAME: begin
                // scan stored entries only, from the head
                scan_ptr = head_ptr;
                for (int p = 0; p + 1 < fill_count && frame_len == 0; p++) begin
                    next_ptr = scan_ptr + 1'b1;
                    if (fifo_mem[scan_ptr] == delim_lead && fifo_mem[next_ptr] == delim_trail)
                        frame_len = p + 2;
                    scan_ptr = next_ptr;
                end
                if (frame_len == 0) begin
                    queue_beat(1'b0, '0, 1'b1);
                end else begin
                    for (int k = 0; k < frame_len; k++) begin
                        v = fifo_mem[head_ptr];
                        head_ptr = head_ptr + 1'b1;
                        fill_count--;
                        queue_beat(1'b1, v, k + 1 == frame_len);
                    end
                end
            end
            CMD_CHECK: begin
                newest = tail_ptr - 1'b1;
                older  = tail_ptr - 2'd2;
                if (delim_lead == '0 && delim_trail == '0)
                    seen = 1'b1;
                else if (fill_count >= 2)
                    seen = fifo_mem[older] == delim_lead && fifo_mem[newest] == delim_trail;
                else
                    seen = 1'b0;
                queue_beat(seen, '0, 1'b1);
            end
        endcase
    endtask

    // Offer one transaction, hold until accepted, then maybe idle a while
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] din);
        int gap;
        s_tdata  <= {{(S_TDATA_W - CMD_W - BYTE_W){1'b0}}, din, cmd};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        apply_fifo_command(cmd, din);
        if (!steady_flow && $urandom_range(0, 1) == 1) begin
            gap = pick_gap();
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (due_beats.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write both delimiter registers back to back; block must be idle
    task automatic set_delimiters(input logic [BYTE_W-1:0] lead,
                                  input logic [BYTE_W-1:0] trail);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_DELIM_FIRST;
        cfg_wdata <= lead;
        @(posedge aclk);
        cfg_idx   <= CFG_DELIM_SECOND;
        cfg_wdata <= trail;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        delim_lead  = lead;
        delim_trail = trail;
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // Result channel: check each transaction, pace m_tready
    initial begin : result_check
        beat_t got;
        beat_t want;
        int    stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.ok   = m_tdata[0];
                got.data = m_tdata[BYTE_W:1];
                got.fill = m_tdata[BYTE_W + FILL_W:BYTE_W + 1];
                got.last = m_tlast;
                if (due_beats.size() == 0) begin
                    $display("%0t ns: result with nothing pending, tdata %h tlast %b",
                             $time, m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = due_beats.pop_front();
                    check_field("ok", int'(want.ok), int'(got.ok));
                    check_field("data_out", int'(want.data), int'(got.data));
                    check_field("last", int'(want.last), int'(got.last));
                    check_field("fill_level", int'(want.fill), int'(got.fill));
                end
            end
            // long hold-off on request, otherwise random stalls
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Empty and near-empty refusals, zero and all-ones delimiters
    task automatic test_directed_corners();
        // delimiters still at their reset value of zero
        send_item(CMD_POP, 8'hFF);
        send_item(CMD_FRAME, 8'h00);
        send_item(CMD_CHECK, 8'h00);
        send_item(CMD_PUSH, 8'h00);
        send_item(CMD_FRAME, 8'h00);
        send_item(CMD_PUSH, 8'h00);
        send_item(CMD_FRAME, 8'h00);
        settle_idle();
        set_delimiters(8'hFF, 8'hFF);
        send_item(CMD_CHECK, 8'h00);
        send_item(CMD_PUSH, 8'hFF);
        send_item(CMD_CHECK, 8'hFF);
        send_item(CMD_PUSH, 8'hFF);
        send_item(CMD_CHECK, 8'h00);
        send_item(CMD_PUSH, 8'hAA);
        send_item(CMD_CHECK, 8'h00);
        send_item(CMD_PUSH, 8'h55);
        send_item(CMD_PUSH, 8'hFF);
        send_item(CMD_PUSH, 8'hFF);
        // delimiter right at the head, then a longer frame behind it
        send_item(CMD_FRAME, 8'h00);
        send_item(CMD_FRAME, 8'h00);
        send_item(CMD_POP, 8'h00);
        // lone first delimiter byte: scan over stored entries finds no pair
        send_item(CMD_PUSH, 8'h12);
        send_item(CMD_PUSH, 8'hFF);
        send_item(CMD_FRAME, 8'hFF);
        send_item(CMD_POP, 8'h00);
        send_item(CMD_POP, 8'h00);
    endtask

    // Stall the result side while pushing past full, then drain by frames
    task automatic test_backpressure_fill();
        int pushes;
        int level_then;
        settle_idle();
        set_delimiters(8'h0D, 8'h0A);
        hold_request = 250;
        pushes = FIFO_DEPTH - fill_count + 2;
        for (int i = 0; i < pushes; i++) begin
            if (i % 6 == 4)
                send_item(CMD_PUSH, delim_lead);
            else if (i % 6 == 5)
                send_item(CMD_PUSH, delim_trail);
            else
                send_item(CMD_PUSH, BYTE_W'($urandom_range(0, 255)));
        end
        send_item(CMD_CHECK, 8'h00);
        settle_idle();
        // sender paused above until all results came; now drain
        while (fill_count > 0) begin
            level_then = fill_count;
            send_item(CMD_FRAME, BYTE_W'($urandom_range(0, 255)));
            if (fill_count == level_then)
                send_item(CMD_POP, BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    // Random frames: mostly payload plus delimiter, then pops, checks, noise
    task automatic test_random_frames(input logic [BYTE_W-1:0] lead,
                                      input logic [BYTE_W-1:0] trail,
                                      input int n_items, input bit gapless);
        int sent;
        int r;
        int payload;
        settle_idle();
        set_delimiters(lead, trail);
        steady_flow = gapless;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                payload = $urandom_range(0, 5);
                repeat (payload) send_item(CMD_PUSH, pick_byte());
                send_item(CMD_PUSH, delim_lead);
                send_item(CMD_PUSH, delim_trail);
                sent += payload + 2;
                if ($urandom_range(0, 1) == 1) begin
                    send_item(CMD_CHECK, BYTE_W'($urandom_range(0, 255)));
                    sent++;
                end
            end else if (r < 65) begin
                send_item(CMD_FRAME, BYTE_W'($urandom_range(0, 255)));
                sent++;
            end else if (r < 78) begin
                send_item(CMD_POP, BYTE_W'($urandom_range(0, 255)));
                sent++;
            end else if (r < 88) begin
                send_item(CMD_CHECK, BYTE_W'($urandom_range(0, 255)));
                sent++;
            end else begin
                // broken sequence: a lone first delimiter byte or plain noise
                send_item(CMD_PUSH, ($urandom_range(0, 1) == 1)
                                    ? delim_lead
                                    : BYTE_W'($urandom_range(0, 255)));
                sent++;
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin : stimulus
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_idx   <= CFG_DELIM_FIRST;
        cfg_wdata <= '0;
        aresetn   <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_corners();
        test_backpressure_fill();
        test_random_frames(8'h00, 8'h00, 16, 1'b0);
        test_random_frames(8'hFF, 8'h00, 16, 1'b0);
        test_random_frames(8'h0D, 8'h0A, 16, 1'b1);
        test_random_frames(BYTE_W'($urandom_range(0, 255)),
                           BYTE_W'($urandom_range(0, 255)), 16, 1'b0);

        settle_idle();
        repeat (20) @(posedge aclk);
        if (errors == 0 && due_beats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/dlmfifo_pkg.sv
rtl/core/dlmfifo_ctrl.sv
rtl/core/dlmfifo_dp.sv
rtl/core/delimited_frame_fifo.sv
sim/delimited_frame_fifo_test.sv
